>>> rtl/trpf_pkg.sv
// Package for the tilemap rectangle palette fill block.
// Holds the opcode and state types and the clipping constants.
// Depends on nothing; used by tilemap_rect_palette_fill.
`timescale 1ns / 1ps
`default_nettype none

package trpf_pkg;

   localparam int unsigned MAP_COLUMNS = 32;
   localparam int unsigned MAP_ROWS    = 32;
   localparam int unsigned STORE_DEPTH = MAP_COLUMNS * MAP_ROWS;
   localparam int unsigned INDEX_WIDTH = $clog2(STORE_DEPTH);
   localparam int unsigned COORD_WIDTH = $clog2(MAP_COLUMNS);
   localparam int unsigned ENTRY_WIDTH = 16;
   localparam int unsigned MASK_WIDTH  = 8;

   // Clipping bounds; the vertical span is deliberately narrower than the limit.
   localparam logic signed [9:0] CLIP_X_LIMIT = 10'sd29;
   localparam logic signed [9:0] CLIP_X_SPAN  = 10'sd30;
   localparam logic signed [9:0] CLIP_Y_LIMIT = 10'sd29;
   localparam logic signed [9:0] CLIP_Y_SPAN  = 10'sd20;

   localparam logic [3:0] PALETTE_ALL = 4'hf;

   typedef enum logic [1:0] {
      OP_FILL  = 2'd0,
      OP_WRITE = 2'd1,
      OP_READ  = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_FILL   = 5'b00010,
      ST_DRAIN  = 5'b00100,
      ST_RDWAIT = 5'b01000,
      ST_DONE   = 5'b10000
   } state_type;

endpackage

`default_nettype wire

>>> rtl/tilemap_rect_palette_fill.sv
// Tilemap rectangle palette fill: 32x32 tile store with a row-group dirty mask.
// A fill reads every clipped entry, at most 30*29 = 870 of them, through the single tile
// memory and writes back, with the fill palette, only those whose palette is the wildcard.
// One transaction is worked on at a time; the next one is taken only after the result
// has been handed to the response register.
// Reset clears the dirty mask and the control state; the tile store is not cleared.
// Depends on trpf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tilemap_rect_palette_fill (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  trpf_pkg::opcode_type   req_opcode,
   input  logic signed [7:0]      req_rect_x,
   input  logic signed [7:0]      req_rect_y,
   input  logic signed [7:0]      req_rect_width,
   input  logic signed [7:0]      req_rect_height,
   input  logic [3:0]             req_fill_palette,
   input  logic [9:0]             req_entry_index,
   input  logic [15:0]            req_entry_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [15:0]            rsp_read_data,
   output logic [7:0]             rsp_dirty_mask
);

   import trpf_pkg::*;

   logic [ENTRY_WIDTH-1:0] tile_mem [STORE_DEPTH];

   state_type              state_ff, state_in;
   logic [COORD_WIDTH-1:0] row_ff, row_in;
   logic [COORD_WIDTH-1:0] col_ff, col_in;
   logic [COORD_WIDTH-1:0] col_first_ff, col_first_in;
   logic [COORD_WIDTH-1:0] col_last_ff, col_last_in;
   logic [COORD_WIDTH-1:0] row_last_ff, row_last_in;
   logic [3:0]             palette_ff, palette_in;
   logic                   wb_valid_ff, wb_valid_in;
   logic [INDEX_WIDTH-1:0] wb_addr_ff, wb_addr_in;
   logic [MASK_WIDTH-1:0]  dirty_ff, dirty_in;
   logic [ENTRY_WIDTH-1:0] rdata_ff, rdata_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [ENTRY_WIDTH-1:0] rsp_data_ff, rsp_data_in;
   logic [MASK_WIDTH-1:0]  rsp_mask_ff, rsp_mask_in;

   logic [ENTRY_WIDTH-1:0] mem_q;
   logic                   mem_we;
   logic [INDEX_WIDTH-1:0] mem_waddr;
   logic [ENTRY_WIDTH-1:0] mem_wdata;
   logic [INDEX_WIDTH-1:0] mem_raddr;

   logic                   req_accept;
   logic                   rsp_free;
   logic signed [9:0]      x_ext, y_ext, w_ext, h_ext;
   logic signed [9:0]      x_start, y_start, x_end_raw, y_end_raw, x_end, y_end;
   logic signed [9:0]      x_last, y_last;
   logic                   fill_ok;
   logic [2:0]             group;
   logic [2:0]             dirty_bit;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   // Clipping. The end bound is the same before and after moving a negative origin to zero.
   always_comb begin
      x_ext     = 10'(req_rect_x);
      y_ext     = 10'(req_rect_y);
      w_ext     = 10'(req_rect_width);
      h_ext     = 10'(req_rect_height);
      x_start   = (x_ext < 10'sd0) ? 10'sd0 : x_ext;
      y_start   = (y_ext < 10'sd0) ? 10'sd0 : y_ext;
      x_end_raw = x_ext + w_ext;
      y_end_raw = y_ext + h_ext;
      x_end     = (x_end_raw > CLIP_X_LIMIT) ? CLIP_X_SPAN : x_end_raw;
      y_end     = (y_end_raw > CLIP_Y_LIMIT) ? CLIP_Y_SPAN : y_end_raw;
      x_last    = x_end - 10'sd1;
      y_last    = y_end - 10'sd1;
      fill_ok   = (x_end > x_start) && (y_end > y_start);
   end

   assign group     = row_ff[COORD_WIDTH-1:2];
   assign dirty_bit = group + 3'd1;

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      col_first_in = col_first_ff;
      col_last_in  = col_last_ff;
      row_last_in  = row_last_ff;
      palette_in   = palette_ff;
      wb_valid_in  = 1'b0;
      wb_addr_in   = wb_addr_ff;
      dirty_in     = dirty_ff;
      rdata_in     = rdata_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      rsp_mask_in  = rsp_mask_ff;
      mem_raddr    = {row_ff, col_ff};
      mem_we       = 1'b0;
      mem_waddr    = wb_addr_ff;
      mem_wdata    = {palette_ff, mem_q[11:0]};

      // Write back the entry read in the previous cycle when its palette is the wildcard.
      if (wb_valid_ff && (mem_q[15:12] == PALETTE_ALL)) begin
         mem_we = 1'b1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               rdata_in     = '0;
               row_in       = y_start[COORD_WIDTH-1:0];
               col_in       = x_start[COORD_WIDTH-1:0];
               col_first_in = x_start[COORD_WIDTH-1:0];
               col_last_in  = x_last[COORD_WIDTH-1:0];
               row_last_in  = y_last[COORD_WIDTH-1:0];
               palette_in   = req_fill_palette;
               mem_raddr    = req_entry_index;
               unique case (req_opcode)
                  OP_FILL:  state_in = fill_ok ? ST_FILL : ST_DONE;
                  OP_WRITE: begin
                     mem_we    = 1'b1;
                     mem_waddr = req_entry_index;
                     mem_wdata = req_entry_data;
                     state_in  = ST_DONE;
                  end
                  OP_READ:  state_in = ST_RDWAIT;
                  default:  state_in = ST_DONE;
               endcase
            end
         end
         ST_FILL: begin
            wb_valid_in = 1'b1;
            wb_addr_in  = {row_ff, col_ff};
            // A row counts as visited when its first entry is issued; row 28 and up set nothing.
            if ((col_ff == col_first_ff) && (group != 3'd7)) begin
               dirty_in[dirty_bit] = 1'b1;
            end
            if (col_ff == col_last_ff) begin
               col_in = col_first_ff;
               row_in = row_ff + 1'b1;
               if (row_ff == row_last_ff) begin
                  state_in = ST_DRAIN;
               end
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_RDWAIT: begin
            rdata_in = mem_q;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = rdata_ff;
               rsp_mask_in  = dirty_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         tile_mem[mem_waddr] <= mem_wdata;
      end
      mem_q <= tile_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wb_valid_ff  <= 1'b0;
         dirty_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wb_valid_ff  <= wb_valid_in;
         dirty_ff     <= dirty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff       <= row_in;
      col_ff       <= col_in;
      col_first_ff <= col_first_in;
      col_last_ff  <= col_last_in;
      row_last_ff  <= row_last_in;
      palette_ff   <= palette_in;
      wb_addr_ff   <= wb_addr_in;
      rdata_ff     <= rdata_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_mask_ff  <= rsp_mask_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_data  = rsp_data_ff;
   assign rsp_dirty_mask = rsp_mask_ff;

   // A pending write-back always comes from an entry issued in the fill state.
   assert property (@(posedge clock) disable iff (reset)
      wb_valid_ff |-> ($past(state_ff) == ST_FILL))
      else $error("write-back without a preceding fill read");

   // Fill write-backs stay inside the clipped columns.
   assert property (@(posedge clock) disable iff (reset)
      (mem_we && (state_ff != ST_IDLE)) |-> (mem_waddr[COORD_WIDTH-1:0] <= 5'd29))
      else $error("fill write-back outside the clipped columns");

   // Dirty bits only accumulate until reset.
   assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> ((dirty_ff & $past(dirty_ff)) == $past(dirty_ff)))
      else $error("dirty bit lost");

   // Bit zero of the dirty mask is never set.
   assert property (@(posedge clock) disable iff (reset)
      dirty_ff[0] == 1'b0)
      else $error("dirty bit zero set");

   // The drain cycle always hands over to the result stage.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |=> (state_ff == ST_DONE))
      else $error("drain did not complete");

endmodule

`default_nettype wire
